// ===== rtl/core/lc3_exec_pkg.sv =====
// ----------------------------------------------------------------------------
// LC-3 subset execute unit package
// Shared word types, opcode and condition code constants, decoded item format.
// ----------------------------------------------------------------------------
package lc3_exec_pkg;

   localparam int WORD_BITS    = 16;
   localparam int REG_COUNT    = 8;
   localparam int REG_IDX_BITS = 3;

   localparam logic [3:0] OPC_BR  = 4'd0;
   localparam logic [3:0] OPC_ADD = 4'd1;
   localparam logic [3:0] OPC_AND = 4'd5;
   localparam logic [3:0] OPC_NOT = 4'd9;
   localparam logic [3:0] OPC_LDI = 4'd10;

   localparam logic [2:0] FLAG_N = 3'd4;
   localparam logic [2:0] FLAG_Z = 3'd2;
   localparam logic [2:0] FLAG_P = 3'd1;

   localparam logic [WORD_BITS-1:0] PC_RESET = 16'h3000;

   typedef struct packed {
      logic        op;
      logic [15:0] instr;
      logic [15:0] load_addr;
      logic [15:0] load_data;
   } req_type;

   typedef struct packed {
      logic [15:0] pc_now;
      logic [2:0]  flags;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        illegal;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_MEMWR   = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_AND     = 3'd2,
      KIND_NOT     = 3'd3,
      KIND_BR      = 3'd4,
      KIND_LDI     = 3'd5,
      KIND_ILLEGAL = 3'd6
   } kind_type;

   // Item as classified by the front end.
   typedef struct packed {
      kind_type                kind;
      logic [REG_IDX_BITS-1:0] dr;
      logic [REG_IDX_BITS-1:0] sr1;
      logic [REG_IDX_BITS-1:0] sr2;
      logic                    imm_sel;
      logic [WORD_BITS-1:0]    imm;
      logic [WORD_BITS-1:0]    off9;
      logic [WORD_BITS-1:0]    load_addr;
      logic [WORD_BITS-1:0]    load_data;
   } dec_type;

endpackage

// ===== rtl/core/lc3_exec_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lc3_exec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lc3_exec_front.sv =====
// ----------------------------------------------------------------------------
// LC-3 execute front end
// Accepts request words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lc3_exec_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lc3_exec_pkg::req_type req_word,
   output logic                  q_valid,
   output lc3_exec_pkg::dec_type q_item,
   input  logic                  q_pop
);

   lc3_exec_pkg::dec_type dec;
   lc3_exec_pkg::dec_type slot_ff [2];
   logic [1:0]            count_ff, count_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic                  push;

   // Instruction decode.
   always_comb begin
      dec           = '0;
      dec.dr        = req_word.instr[11:9];
      dec.sr1       = req_word.instr[8:6];
      dec.sr2       = req_word.instr[2:0];
      dec.imm_sel   = req_word.instr[5];
      dec.imm       = {{11{req_word.instr[4]}}, req_word.instr[4:0]};
      dec.off9      = {{7{req_word.instr[8]}}, req_word.instr[8:0]};
      dec.load_addr = req_word.load_addr;
      dec.load_data = req_word.load_data;
      if (req_word.op) begin
         dec.kind = lc3_exec_pkg::KIND_MEMWR;
      end else begin
         unique case (req_word.instr[15:12])
            lc3_exec_pkg::OPC_ADD: dec.kind = lc3_exec_pkg::KIND_ADD;
            lc3_exec_pkg::OPC_AND: dec.kind = lc3_exec_pkg::KIND_AND;
            lc3_exec_pkg::OPC_NOT: dec.kind = lc3_exec_pkg::KIND_NOT;
            lc3_exec_pkg::OPC_BR:  dec.kind = lc3_exec_pkg::KIND_BR;
            lc3_exec_pkg::OPC_LDI: dec.kind = lc3_exec_pkg::KIND_LDI;
            default:               dec.kind = lc3_exec_pkg::KIND_ILLEGAL;
         endcase
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/core/lc3_exec_back.sv =====
// ----------------------------------------------------------------------------
// LC-3 execute back end
// Carries out queued items against the register file, PC, flags and memory.
// ----------------------------------------------------------------------------
module lc3_exec_back #(
   parameter int ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  lc3_exec_pkg::dec_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lc3_exec_pkg::rsp_type rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_IND  = 3'b100
   } back_state_type;

   localparam int MEM_DEPTH = 2 ** ADDR_BITS;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) begin
         f = lc3_exec_pkg::FLAG_Z;
      end else if (v[15]) begin
         f = lc3_exec_pkg::FLAG_N;
      end else begin
         f = lc3_exec_pkg::FLAG_P;
      end
      return f;
   endfunction

   back_state_type        state_ff, state_in;
   logic [15:0]           pc_ff, pc_in;
   logic [2:0]            flags_ff, flags_in;
   logic [7:0]            rf_vld_ff, rf_vld_in;
   logic                  va_ff, va_in;
   logic                  vb_ff, vb_in;
   lc3_exec_pkg::dec_type cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lc3_exec_pkg::rsp_type rsp_ff, rsp_in;

   logic                  out_free;
   logic                  rsp_ld;
   lc3_exec_pkg::rsp_type rsp_next;
   logic                  rf_we;
   logic [15:0]           wb_val;
   logic [15:0]           rfa_rdata, rfb_rdata;
   logic [15:0]           opa, opb, alu_val;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_raddr;
   logic [15:0]           mem_rdata;
   logic [15:0]           ldi_addr;
   logic                  br_taken;

   // Two copies of the register file give two read ports.
   lc3_exec_ram #(.WIDTH(16), .DEPTH(lc3_exec_pkg::REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (cur_ff.dr),
      .wr_data (wb_val),
      .rd_addr (q_item.sr1),
      .rd_data (rfa_rdata)
   );

   lc3_exec_ram #(.WIDTH(16), .DEPTH(lc3_exec_pkg::REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (cur_ff.dr),
      .wr_data (wb_val),
      .rd_addr (q_item.sr2),
      .rd_data (rfb_rdata)
   );

   lc3_exec_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (q_item.load_addr[ADDR_BITS-1:0]),
      .wr_data (q_item.load_data),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = q_valid && (state_ff == ST_IDLE) && out_free;
   assign ldi_addr = pc_ff + 16'd1 + q_item.off9;
   assign br_taken = |(q_item.dr & flags_ff);

   // First LDI read uses PC plus one plus offset, the second uses the pointer just read.
   assign mem_raddr = (state_ff == ST_EXEC) ? mem_rdata[ADDR_BITS-1:0]
                                            : ldi_addr[ADDR_BITS-1:0];

   // Registers that were never written read as zero.
   assign opa = va_ff ? rfa_rdata : 16'd0;
   assign opb = cur_ff.imm_sel ? cur_ff.imm : (vb_ff ? rfb_rdata : 16'd0);

   always_comb begin
      case (cur_ff.kind)
         lc3_exec_pkg::KIND_ADD: alu_val = opa + opb;
         lc3_exec_pkg::KIND_AND: alu_val = opa & opb;
         default:                alu_val = ~opa;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      rf_vld_in = rf_vld_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      cur_in    = cur_ff;
      rf_we     = 1'b0;
      mem_we    = 1'b0;
      wb_val    = 16'd0;
      rsp_ld    = 1'b0;
      rsp_next  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in = q_item;
               va_in  = rf_vld_ff[q_item.sr1];
               vb_in  = rf_vld_ff[q_item.sr2];
               case (q_item.kind) inside
                  lc3_exec_pkg::KIND_MEMWR: begin
                     mem_we         = 1'b1;
                     rsp_ld         = 1'b1;
                     rsp_next.pc_now = pc_ff;
                     rsp_next.flags  = flags_ff;
                  end
                  lc3_exec_pkg::KIND_BR: begin
                     pc_in           = pc_ff + 16'd1 + (br_taken ? q_item.off9 : 16'd0);
                     rsp_ld          = 1'b1;
                     rsp_next.pc_now = pc_in;
                     rsp_next.flags  = flags_ff;
                  end
                  lc3_exec_pkg::KIND_ADD,
                  lc3_exec_pkg::KIND_AND,
                  lc3_exec_pkg::KIND_NOT,
                  lc3_exec_pkg::KIND_LDI: begin
                     pc_in    = pc_ff + 16'd1;
                     state_in = ST_EXEC;
                  end
                  default: begin
                     rsp_ld           = 1'b1;
                     rsp_next.pc_now  = pc_ff;
                     rsp_next.flags   = flags_ff;
                     rsp_next.illegal = 1'b1;
                  end
               endcase
            end
         end
         ST_EXEC, ST_IND: begin
            if (state_ff == ST_EXEC && cur_ff.kind == lc3_exec_pkg::KIND_LDI) begin
               state_in = ST_IND;
            end else begin
               wb_val                = (state_ff == ST_IND) ? mem_rdata : alu_val;
               rf_we                 = 1'b1;
               rf_vld_in[cur_ff.dr]  = 1'b1;
               flags_in              = flags_of(wb_val);
               rsp_ld                = 1'b1;
               rsp_next.pc_now       = pc_ff;
               rsp_next.flags        = flags_in;
               rsp_next.reg_written  = 1'b1;
               rsp_next.reg_index    = cur_ff.dr;
               rsp_next.reg_value    = wb_val;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_ld || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ld ? rsp_next : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= lc3_exec_pkg::PC_RESET;
         flags_ff     <= lc3_exec_pkg::FLAG_Z;
         rf_vld_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         rf_vld_ff    <= rf_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff  <= va_in;
      vb_ff  <= vb_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/core/lc3_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// LC-3 subset execute unit
// Executes ADD, AND, NOT, BR and LDI instructions and takes memory load words.
// ----------------------------------------------------------------------------
// Each request word either executes one LC-3 instruction or stores one word
// into the internal word memory, and each produces exactly one response word
// in order. A front end decodes requests into a two-entry queue, so up to two
// words are taken while the back end is busy or a response is stalled. The
// back end handles one word at a time: a memory store, a branch or an
// unsupported opcode ends in the idle state; ADD, AND and NOT pass the execute
// state, as the register file has a registered read; LDI passes it and then
// the indirect state, as its pointer and its data come from two dependent reads
// of the single memory read port. A response sits in an output register until
// it is taken. Memory words that were never stored read back as undefined data.
module lc3_subset_execute_unit #(
   parameter int ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lc3_exec_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lc3_exec_pkg::rsp_type rsp_word
);

   logic                  q_valid;
   logic                  q_pop;
   lc3_exec_pkg::dec_type q_item;

   // Front end: decode and queue.
   lc3_exec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Back end: register file, PC, flags, memory and the response register.
   lc3_exec_back #(.ADDR_BITS(ADDR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // The back end only takes a word the queue actually holds.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // Nothing is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An unsupported opcode never writes a register.
   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.illegal |-> !rsp_word.reg_written)
      else $error("illegal instruction reported a register write");

   // Register fields are zero when no register was written.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.reg_written |->
         (rsp_word.reg_index == 3'd0) && (rsp_word.reg_value == 16'd0))
      else $error("register fields set without a register write");

endmodule

// ===== tb/lc3_subset_execute_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LC-3 subset execute unit testbench
// Self-checking run against an in-bench model of the architectural state.
// ----------------------------------------------------------------------------
// An initial block builds the whole request stream up front. It starts with
// a short directed list and then adds a long random mix of ADD, AND, NOT,
// BR, LDI, unsupported opcodes and memory stores. A planning copy of the
// model follows the stream while it is built. Every LDI is preceded by the
// stores it needs, so no unwritten memory word is ever read. A run of
// backward branches walks the PC across the 16-bit wrap.
// A clocked driver offers the queued words, and a second copy of the model
// predicts one response per accepted word. A clocked monitor compares each
// accepted response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lc3_subset_execute_unit_tb;

   localparam int ADDR_BITS = 16;
   localparam int MEM_WORDS = 1 << ADDR_BITS;
   localparam logic [15:0] ADDR_MASK = 16'(MEM_WORDS - 1);

   // Opcodes outside the supported subset used by the directed part.
   localparam logic [3:0] OPC_RTI  = 4'd8;
   localparam logic [3:0] OPC_TRAP = 4'd15;

   // Two copies of the architectural state: one follows the stream as it is
   // built, the other follows the words the block actually accepts.
   localparam int PLAN  = 0;
   localparam int TRACK = 1;

   localparam int RANDOM_ITEMS = 600;
   localparam int WALK_FROM    = 300;
   localparam int WALK_LEN     = 70;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 150;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SHOW_MAX     = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   lc3_exec_pkg::req_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   lc3_exec_pkg::rsp_type rsp_word;

   // Architectural state images.
   logic [15:0] gpr_img [0:1][0:lc3_exec_pkg::REG_COUNT-1];
   logic [15:0] pc_img  [0:1];
   logic [2:0]  cc_img  [0:1];
   logic [15:0] mem_img [0:1][0:MEM_WORDS-1];
   bit          mem_set [0:MEM_WORDS-1];

   lc3_exec_pkg::req_type request_q[$];
   lc3_exec_pkg::rsp_type predicted_q[$];

   int  total_items;
   int  offered_cnt;
   int  accepted_cnt;
   int  taken_cnt;
   int  err_cnt;
   int  cycle_cnt;
   int  hold_left;
   bit  hold_done;
   bit  drain_done;
   bit  send_now;
   lc3_exec_pkg::rsp_type want_word;

   lc3_subset_execute_unit #(
      .ADDR_BITS(ADDR_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Execution model
   // ------------------------------------------------------------------------
   function automatic logic [2:0] cond_of(input logic [15:0] v);
      if (v == 16'h0000) return lc3_exec_pkg::FLAG_Z;
      return v[15] ? lc3_exec_pkg::FLAG_N : lc3_exec_pkg::FLAG_P;
   endfunction

   task automatic clear_image(input int img);
      for (int i = 0; i < lc3_exec_pkg::REG_COUNT; i++) gpr_img[img][i] = '0;
      pc_img[img] = lc3_exec_pkg::PC_RESET;
      cc_img[img] = lc3_exec_pkg::FLAG_Z;
   endtask

   // Applies one request word to a state image and returns its response.
   function automatic lc3_exec_pkg::rsp_type predict_exec(input int img,
                                                         input lc3_exec_pkg::req_type w);
      lc3_exec_pkg::rsp_type r;
      logic [3:0]  opc;
      logic [2:0]  dr;
      logic [2:0]  sr1;
      logic [15:0] b;
      logic [15:0] v;
      logic [15:0] off9;
      logic [15:0] ptr;
      bit          wr;
      r    = '0;
      v    = '0;
      wr   = 1'b0;
      opc  = w.instr[15:12];
      dr   = w.instr[11:9];
      sr1  = w.instr[8:6];
      off9 = {{7{w.instr[8]}}, w.instr[8:0]};
      if (w.op) begin
         mem_img[img][w.load_addr & ADDR_MASK] = w.load_data;
      end else begin
         case (opc) inside
            lc3_exec_pkg::OPC_ADD, lc3_exec_pkg::OPC_AND: begin
               pc_img[img] = pc_img[img] + 16'd1;
               b = w.instr[5] ? {{11{w.instr[4]}}, w.instr[4:0]}
                              : gpr_img[img][w.instr[2:0]];
               v = (opc == lc3_exec_pkg::OPC_ADD) ? gpr_img[img][sr1] + b
                                                  : gpr_img[img][sr1] & b;
               wr = 1'b1;
            end
            lc3_exec_pkg::OPC_NOT: begin
               pc_img[img] = pc_img[img] + 16'd1;
               v = ~gpr_img[img][sr1];
               wr = 1'b1;
            end
            lc3_exec_pkg::OPC_BR: begin
               // A zero condition field never matches, so it never branches.
               pc_img[img] = pc_img[img] + 16'd1;
               if ((dr & cc_img[img]) != 3'b000) pc_img[img] = pc_img[img] + off9;
            end
            lc3_exec_pkg::OPC_LDI: begin
               pc_img[img] = pc_img[img] + 16'd1;
               ptr = mem_img[img][(pc_img[img] + off9) & ADDR_MASK];
               v = mem_img[img][ptr & ADDR_MASK];
               wr = 1'b1;
            end
            default: begin
               // Unsupported opcode: nothing changes, not even the PC.
               r.illegal = 1'b1;
            end
         endcase
         if (wr) begin
            gpr_img[img][dr] = v;
            cc_img[img] = cond_of(v);
         end
      end
      r.pc_now      = pc_img[img];
      r.flags       = cc_img[img];
      r.reg_written = wr;
      r.reg_index   = wr ? dr : 3'd0;
      r.reg_value   = v;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stream building
   // ------------------------------------------------------------------------
   task automatic queue_word(input lc3_exec_pkg::req_type w);
      void'(predict_exec(PLAN, w));
      if (w.op) mem_set[w.load_addr & ADDR_MASK] = 1'b1;
      request_q.push_back(w);
   endtask

   task automatic queue_store(input logic [15:0] addr, input logic [15:0] data);
      lc3_exec_pkg::req_type w;
      w.op        = 1'b1;
      w.instr     = 16'($urandom);
      w.load_addr = addr;
      w.load_data = data;
      queue_word(w);
   endtask

   task automatic queue_instr(input logic [15:0] instr);
      lc3_exec_pkg::req_type w;
      w.op        = 1'b0;
      w.instr     = instr;
      w.load_addr = 16'($urandom);
      w.load_data = 16'($urandom);
      queue_word(w);
   endtask

   // LDI reads a pointer at PC+1+offset and then the word it points to. Both
   // must have been stored first, so a fresh pair is stored here if one is
   // missing or at random, data before pointer in case the two addresses coincide.
   task automatic queue_ldi(input logic [15:0] instr);
      logic [15:0] slot;
      logic [15:0] ptr;
      slot = (pc_img[PLAN] + 16'd1 + {{7{instr[8]}}, instr[8:0]}) & ADDR_MASK;
      if (!mem_set[slot] || !mem_set[mem_img[PLAN][slot] & ADDR_MASK] ||
          $urandom_range(99) < 30) begin
         ptr = 16'($urandom);
         queue_store(ptr, 16'($urandom));
         queue_store(slot, ptr);
      end
      queue_instr(instr);
   endtask

   function automatic logic [3:0] unsupported_opcode();
      logic [3:0] o;
      o = 4'($urandom);
      while (o == lc3_exec_pkg::OPC_BR || o == lc3_exec_pkg::OPC_ADD ||
             o == lc3_exec_pkg::OPC_AND || o == lc3_exec_pkg::OPC_NOT ||
             o == lc3_exec_pkg::OPC_LDI)
         o = 4'($urandom);
      return o;
   endfunction

   // Sender idles 10% then 52% then never; the receiver the other way round.
   function automatic int phase_now();
      if (accepted_cnt < total_items / 3) return 0;
      if (accepted_cnt < 2 * total_items / 3) return 1;
      return 2;
   endfunction

   // ------------------------------------------------------------------------
   // Checking helpers
   // ------------------------------------------------------------------------
   task automatic note_error(input string msg);
      err_cnt++;
      if (err_cnt <= SHOW_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want)
         note_error($sformatf("response %0d %s: expected 0x%0h, got 0x%0h",
                              taken_cnt, name, want, got));
   endtask

   // ------------------------------------------------------------------------
   // Driver: new words change at the falling edge; a word that is offered
   // stays put until the block takes it.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && offered_cnt != accepted_cnt)) begin
         send_now = request_q.size() != 0;
         case (phase_now())
            0: if ($urandom_range(99) < 10) send_now = 1'b0;
            1: if ($urandom_range(99) < 52) send_now = 1'b0;
            default: ;
         endcase
         // Once, halfway through, wait for the block to drain completely.
         if (!drain_done && accepted_cnt == total_items / 2) begin
            if (predicted_q.size() != 0) send_now = 1'b0;
            else drain_done = 1'b1;
         end
         req_valid <= send_now;
         if (send_now) begin
            req_word <= request_q[0];
            offered_cnt++;
         end
      end
   end

   // The accepted word is the head of the request queue.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predicted_q.push_back(predict_exec(TRACK, req_word));
         void'(request_q.pop_front());
         accepted_cnt++;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls per phase, plus one long hold-off that lets the
   // block fill up and push back on its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && taken_cnt == HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (phase_now())
            0: rsp_stall <= $urandom_range(99) < 52;
            1: rsp_stall <= $urandom_range(99) < 10;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Monitor: each taken response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         taken_cnt++;
         if (predicted_q.size() == 0) begin
            note_error($sformatf("response %0d arrived with nothing expected",
                                 taken_cnt));
         end else begin
            want_word = predicted_q.pop_front();
            check_field("pc_now", want_word.pc_now, rsp_word.pc_now);
            check_field("flags", 16'(want_word.flags), 16'(rsp_word.flags));
            check_field("reg_written", 16'(want_word.reg_written),
                        16'(rsp_word.reg_written));
            check_field("reg_index", 16'(want_word.reg_index),
                        16'(rsp_word.reg_index));
            check_field("reg_value", want_word.reg_value, rsp_word.reg_value);
            check_field("illegal", 16'(want_word.illegal), 16'(rsp_word.illegal));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stream, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      clear_image(PLAN);
      clear_image(TRACK);

      // Stores at both ends of the address and data range.
      queue_store(16'h0000, 16'h0000);
      queue_store(16'hFFFF, 16'hFFFF);
      // Largest and smallest immediates, then the register forms.
      queue_instr({lc3_exec_pkg::OPC_ADD, 3'd1, 3'd0, 1'b1, 5'h0F});
      queue_instr({lc3_exec_pkg::OPC_ADD, 3'd2, 3'd0, 1'b1, 5'h10});
      queue_instr({lc3_exec_pkg::OPC_ADD, 3'd3, 3'd1, 1'b0, 2'b11, 3'd2});
      queue_instr({lc3_exec_pkg::OPC_AND, 3'd4, 3'd3, 1'b0, 2'b00, 3'd1});
      queue_instr({lc3_exec_pkg::OPC_AND, 3'd5, 3'd3, 1'b1, 5'h00});
      queue_instr({lc3_exec_pkg::OPC_AND, 3'd7, 3'd7, 1'b1, 5'h1F});
      // NOT of a register holding all ones, then of one holding zero.
      queue_instr({lc3_exec_pkg::OPC_NOT, 3'd6, 3'd3, 6'h3F});
      queue_instr({lc3_exec_pkg::OPC_NOT, 3'd7, 3'd0, 6'h3F});
      // Branches: an empty condition, taken and not taken, both offset ends.
      queue_instr({lc3_exec_pkg::OPC_BR, 3'b000, 9'h0FF});
      queue_instr({lc3_exec_pkg::OPC_BR, 3'b100, 9'h0FF});
      queue_instr({lc3_exec_pkg::OPC_BR, 3'b001, 9'h100});
      queue_instr({lc3_exec_pkg::OPC_BR, 3'b111, 9'h100});
      queue_instr({lc3_exec_pkg::OPC_ADD, 3'd0, 3'd0, 1'b1, 5'h00});
      queue_instr({lc3_exec_pkg::OPC_BR, 3'b010, 9'h001});
      // LDI at both offset extremes.
      queue_ldi({lc3_exec_pkg::OPC_LDI, 3'd1, 9'h0FF});
      queue_ldi({lc3_exec_pkg::OPC_LDI, 3'd2, 9'h100});
      // Unsupported opcodes leave everything alone.
      queue_instr({OPC_TRAP, 12'hFFF});
      queue_instr({OPC_RTI, 12'h000});

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         int pick;
         pick = $urandom_range(99);
         if (n >= WALK_FROM && n < WALK_FROM + WALK_LEN)
            // Always-taken backward branches carry the PC through zero.
            queue_instr({lc3_exec_pkg::OPC_BR, 3'b111, 5'b10000, 4'($urandom)});
         else if (pick < 8)
            queue_store(16'($urandom), 16'($urandom));
         else if (pick < 26)
            queue_instr({lc3_exec_pkg::OPC_ADD, 12'($urandom)});
         else if (pick < 40)
            queue_instr({lc3_exec_pkg::OPC_AND, 12'($urandom)});
         else if (pick < 50)
            queue_instr({lc3_exec_pkg::OPC_NOT, 12'($urandom)});
         else if (pick < 65)
            queue_instr({lc3_exec_pkg::OPC_BR, 12'($urandom)});
         else if (pick < 90)
            queue_ldi({lc3_exec_pkg::OPC_LDI, 12'($urandom)});
         else
            queue_instr({unsupported_opcode(), 12'($urandom)});
      end
      total_items = request_q.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || predicted_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_cnt == 0 && predicted_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
